FILE: sv/esfe_pkg.sv
// ----------------------------------------------------------------------------
// esfe_pkg
// Shared types and constants of the escaped frame encoder: item structs,
// the job record passed from the front to the back, and the byte slots.
// ----------------------------------------------------------------------------
package esfe_pkg;

    localparam logic [7:0] ESC_BYTE = 8'h10;
    localparam logic [7:0] END_BYTE = 8'h03;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int JOBQ_DEPTH = 4;

    typedef struct packed {
        logic        kind;
        logic        ack_req;
        logic [7:0]  command;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic        is_hdr;
        logic        ack;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic [7:0]  dat;
        logic        close;
        logic [15:0] sum;
    } job_t;

    typedef enum logic [9:0] {
        SLOT_SYNC   = 10'b00_0000_0001,
        SLOT_ACK    = 10'b00_0000_0010,
        SLOT_CMD    = 10'b00_0000_0100,
        SLOT_LEN_LO = 10'b00_0000_1000,
        SLOT_LEN_HI = 10'b00_0001_0000,
        SLOT_DATA   = 10'b00_0010_0000,
        SLOT_SUM_LO = 10'b00_0100_0000,
        SLOT_SUM_HI = 10'b00_1000_0000,
        SLOT_ESC    = 10'b01_0000_0000,
        SLOT_END    = 10'b10_0000_0000
    } slot_t;

endpackage

FILE: sv/esfe_front.sv
// ----------------------------------------------------------------------------
// esfe_front
// Accepts input items, tracks the open frame, length and running sum, drops
// items of the wrong kind and hands one job per valid item to the queue.
// ----------------------------------------------------------------------------
module esfe_front
    import esfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t in_item,
    input  logic     q_full,
    output logic     full,
    output logic     job_push,
    output job_t     job
);

    logic        frame_open_reg, frame_open_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] running_sum_reg, running_sum_next;

    logic        accept;
    logic [15:0] hdr_sum;
    logic [15:0] dat_sum;
    logic [15:0] left_dec;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign hdr_sum = 16'(ESC_BYTE) + 16'(in_item.ack_req) + 16'(in_item.command)
                   + 16'(in_item.payload_length[7:0]) + 16'(in_item.payload_length[15:8]);
    assign dat_sum  = running_sum_reg + 16'(in_item.data_byte);
    assign left_dec = bytes_left_reg - 16'd1;

    always_comb
    begin
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        job_push         = 1'b0;
        job.is_hdr       = (in_item.kind == KIND_HEADER);
        job.ack          = in_item.ack_req;
        job.cmd          = in_item.command;
        job.len          = in_item.payload_length;
        job.dat          = in_item.data_byte;
        job.close        = 1'b0;
        job.sum          = hdr_sum;
        if (accept)
        begin
            if (in_item.kind == KIND_HEADER && !frame_open_reg)
            begin
                job_push  = 1'b1;
                job.close = (in_item.payload_length == 16'd0);
                job.sum   = hdr_sum;
                if (in_item.payload_length != 16'd0)
                begin
                    frame_open_next  = 1'b1;
                    bytes_left_next  = in_item.payload_length;
                    running_sum_next = hdr_sum;
                end
            end
            else if (in_item.kind == KIND_PAYLOAD && frame_open_reg)
            begin
                job_push  = 1'b1;
                job.close = (left_dec == 16'd0);
                job.sum   = dat_sum;
                if (left_dec == 16'd0)
                begin
                    frame_open_next  = 1'b0;
                    bytes_left_next  = 16'd0;
                    running_sum_next = 16'd0;
                end
                else
                begin
                    bytes_left_next  = left_dec;
                    running_sum_next = dat_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= 16'd0;
            running_sum_reg <= 16'd0;
        end
        else
        begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

FILE: sv/esfe_jobq.sv
// ----------------------------------------------------------------------------
// esfe_jobq
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module esfe_jobq
    import esfe_pkg::*;
#(
    parameter int DEPTH = JOBQ_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic q_full,
    input  logic rd_en,
    output logic rd_valid,
    output job_t rd_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t            slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign q_full   = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/esfe_back.sv
// ----------------------------------------------------------------------------
// esfe_back
// Steps through the byte slots of the head job, one wire byte per cycle
// when the output is free, doubles escape bytes and fills the output register.
// ----------------------------------------------------------------------------
module esfe_back
    import esfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    slot_t     slot_reg, slot_next;
    logic      started_reg, started_next;
    logic      dup_reg, dup_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    slot_t      cur_slot;
    slot_t      nxt_slot;
    logic       done;
    logic       advance;
    logic       stuff;
    logic       stuffable;
    logic [7:0] cur_byte;

    assign advance  = job_valid && (!out_valid_reg || pop);
    assign cur_slot = started_reg ? slot_reg : (job.is_hdr ? SLOT_SYNC : SLOT_DATA);

    always_comb
    begin
        cur_byte  = ESC_BYTE;
        stuffable = 1'b0;
        nxt_slot  = cur_slot;
        done      = 1'b0;
        case (cur_slot)
            SLOT_SYNC:
            begin
                cur_byte = ESC_BYTE;
                nxt_slot = SLOT_ACK;
            end
            SLOT_ACK:
            begin
                cur_byte = 8'(job.ack);
                nxt_slot = SLOT_CMD;
            end
            SLOT_CMD:
            begin
                cur_byte  = job.cmd;
                stuffable = 1'b1;
                nxt_slot  = SLOT_LEN_LO;
            end
            SLOT_LEN_LO:
            begin
                cur_byte  = job.len[7:0];
                stuffable = 1'b1;
                nxt_slot  = SLOT_LEN_HI;
            end
            SLOT_LEN_HI:
            begin
                cur_byte  = job.len[15:8];
                stuffable = 1'b1;
                nxt_slot  = SLOT_SUM_LO;
                done      = !job.close;
            end
            SLOT_DATA:
            begin
                cur_byte  = job.dat;
                stuffable = 1'b1;
                nxt_slot  = SLOT_SUM_LO;
                done      = !job.close;
            end
            SLOT_SUM_LO:
            begin
                cur_byte  = job.sum[7:0];
                stuffable = 1'b1;
                nxt_slot  = SLOT_SUM_HI;
            end
            SLOT_SUM_HI:
            begin
                cur_byte  = job.sum[15:8];
                stuffable = 1'b1;
                nxt_slot  = SLOT_ESC;
            end
            SLOT_ESC:
            begin
                cur_byte = ESC_BYTE;
                nxt_slot = SLOT_END;
            end
            SLOT_END:
            begin
                cur_byte = END_BYTE;
                nxt_slot = SLOT_SYNC;
                done     = 1'b1;
            end
            default:
            begin
                cur_byte = END_BYTE;
                nxt_slot = SLOT_SYNC;
                done     = 1'b1;
            end
        endcase
    end

    assign stuff   = stuffable && (cur_byte == ESC_BYTE) && !dup_reg;
    assign job_pop = advance && done && !stuff;
    assign empty   = !out_valid_reg;
    assign out_item = out_item_reg;

    always_comb
    begin
        slot_next      = slot_reg;
        started_next   = started_reg;
        dup_next       = dup_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (stuff)
            begin
                slot_next    = cur_slot;
                started_next = 1'b1;
                dup_next     = 1'b1;
            end
            else
            begin
                slot_next    = nxt_slot;
                started_next = !done;
                dup_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.out_byte  <= cur_byte;
            out_item_reg.run_last  <= done && !stuff;
            out_item_reg.frame_end <= (cur_slot == SLOT_END);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_SYNC;
            started_reg   <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            started_reg   <= started_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/escaped_frame_encoder_sum16.sv
// ----------------------------------------------------------------------------
// escaped_frame_encoder_sum16
// Framed byte-stream encoder with escape-byte doubling and a 16-bit sum.
//
// Input queue side: present an item on in_item with push; it transfers on a
// clock edge with push high and full low. A header item opens a frame, payload
// items follow; an item of the wrong kind is taken and dropped.
// Output queue side: while empty is low, out_item holds the oldest wire byte;
// it transfers on a clock edge with pop high. run_last marks the last byte
// of an item, frame_end the closing 0x03.
// On an idle block an item's first byte passes the job queue and then the
// output register. The sequencer gives one wire byte per cycle while the
// output is free: a payload item its data byte, a header its sync, ack,
// command and length bytes; a closing item adds the sum, ESC and END bytes.
// A four-entry job queue lets input transfers run ahead of the sequencer.
// Reset clears the frame state, the job queue and the output valid flag.
// While pop is low the output register holds its byte, the sequencer stops,
// and full rises once the job queue fills.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_sum16
    import esfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = JOBQ_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic q_full;
    logic job_push;
    job_t job_in;
    logic job_valid;
    job_t job_head;
    logic job_pop;

    esfe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (in_item),
        .q_full   (q_full),
        .full     (full),
        .job_push (job_push),
        .job      (job_in)
    );

    esfe_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (job_in),
        .q_full   (q_full),
        .rd_en    (job_pop),
        .rd_valid (job_valid),
        .rd_job   (job_head)
    );

    esfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule

FILE: tb/esfe_frame_checker.sv
// ----------------------------------------------------------------------------
// esfe_frame_checker
// Watches both queue sides of the escaped frame encoder. It predicts the
// stuffed wire bytes of every input transfer from its own copy of the frame
// state, and compares each output transfer with the oldest predicted byte.
// ----------------------------------------------------------------------------
module esfe_frame_checker
    import esfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  in_item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t out_item,
    output int        fail_count,
    output int        pending,
    output int        frames_closed,
    output int        dropped_items,
    output int        bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic        frame_open;
    logic [15:0] bytes_left;
    logic [15:0] run_sum;

    out_item_t   item_bytes[$];
    out_item_t   wire_bytes_q[$];

    task automatic put_byte(input logic [7:0] b, input logic fend);
        out_item_t r;
        r.out_byte  = b;
        r.run_last  = 1'b0;
        r.frame_end = fend;
        item_bytes.push_back(r);
    endtask

    task automatic put_stuffed(input logic [7:0] b);
        put_byte(b, 1'b0);
        if (b == ESC_BYTE)
        begin
            put_byte(b, 1'b0);
        end
    endtask

    task automatic close_frame();
        put_stuffed(run_sum[7:0]);
        put_stuffed(run_sum[15:8]);
        put_byte(ESC_BYTE, 1'b0);
        put_byte(END_BYTE, 1'b1);
        frame_open = 1'b0;
        bytes_left = '0;
        run_sum    = '0;
        frames_closed++;
    endtask

    task automatic encode_item(input in_item_t it);
        out_item_t last;
        item_bytes.delete();
        if (it.kind == KIND_HEADER)
        begin
            if (!frame_open)
            begin
                put_byte(ESC_BYTE, 1'b0);
                put_byte({7'd0, it.ack_req}, 1'b0);
                put_stuffed(it.command);
                put_stuffed(it.payload_length[7:0]);
                put_stuffed(it.payload_length[15:8]);
                run_sum = 16'(ESC_BYTE) + 16'(it.ack_req) + 16'(it.command)
                        + 16'(it.payload_length[7:0]) + 16'(it.payload_length[15:8]);
                bytes_left = it.payload_length;
                frame_open = 1'b1;
                if (it.payload_length == 16'd0)
                begin
                    close_frame();
                end
            end
        end
        else if (frame_open)
        begin
            run_sum = run_sum + 16'(it.data_byte);
            put_stuffed(it.data_byte);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0)
            begin
                close_frame();
            end
        end
        if (item_bytes.size() > 0)
        begin
            last = item_bytes.pop_back();
            last.run_last = 1'b1;
            item_bytes.push_back(last);
            foreach (item_bytes[i])
            begin
                wire_bytes_q.push_back(item_bytes[i]);
            end
        end
        else
        begin
            dropped_items++;
        end
    endtask

    task automatic check_byte(input out_item_t got);
        out_item_t want;
        bytes_checked++;
        if (wire_bytes_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
            begin
                $display("unexpected wire byte %02h last=%b end=%b",
                         got.out_byte, got.run_last, got.frame_end);
            end
        end
        else
        begin
            want = wire_bytes_q.pop_front();
            if (got.out_byte !== want.out_byte || got.run_last !== want.run_last
                || got.frame_end !== want.frame_end)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("mismatch at byte %0d: expected %02h/%b/%b, got %02h/%b/%b",
                             bytes_checked, want.out_byte, want.run_last, want.frame_end,
                             got.out_byte, got.run_last, got.frame_end);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open = 1'b0;
            bytes_left = '0;
            run_sum    = '0;
            wire_bytes_q.delete();
            pending    = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_byte(out_item);
            end
            if (push && !full)
            begin
                encode_item(in_item);
            end
            pending = wire_bytes_q.size();
        end
    end

endmodule

FILE: tb/tb_escaped_frame_encoder_sum16.sv
// ----------------------------------------------------------------------------
// tb_escaped_frame_encoder_sum16
// Drives header and payload items into the escaped frame encoder and pops
// its wire bytes, with random idle bursts on both sides and one long receiver
// hold-off. A checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_escaped_frame_encoder_sum16;
    import esfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 320;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;

    int fail_count;
    int pending;
    int frames_closed;
    int dropped_items;
    int bytes_checked;

    int cycle_count;
    int sent_items;
    int framed_items;
    bit idle_mode;
    bit hold_req;
    int rx_gap;

    escaped_frame_encoder_sum16 u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    esfe_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_item       (in_item),
        .empty         (empty),
        .pop           (pop),
        .out_item      (out_item),
        .fail_count    (fail_count),
        .pending       (pending),
        .frames_closed (frames_closed),
        .dropped_items (dropped_items),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        bit hold_done;
        pop       = 1'b0;
        rx_gap    = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (rx_gap > 0)
            begin
                pop <= 1'b0;
                rx_gap--;
            end
            else if (idle_mode && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                rx_gap = $urandom_range(1, 13) - 1;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel < 2)
            return ESC_BYTE;
        else if (sel == 2)
            return 8'hFF;
        else if (sel == 3)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_item_t make_item(input logic kind, input logic ack,
                                           input logic [7:0] cmd, input logic [15:0] len,
                                           input logic [7:0] dat);
        in_item_t it;
        it.kind           = kind;
        it.ack_req        = ack;
        it.command        = cmd;
        it.payload_length = len;
        it.data_byte      = dat;
        return it;
    endfunction

    function automatic in_item_t rand_item(input logic kind);
        return make_item(kind, 1'($urandom_range(0, 1)), pick_byte(),
                         16'($urandom_range(0, 65535)), pick_byte());
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        if (idle_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_header(input logic ack, input logic [7:0] cmd, input logic [15:0] len);
        in_item_t it;
        it = rand_item(KIND_HEADER);
        it.ack_req        = ack;
        it.command        = cmd;
        it.payload_length = len;
        send_item(it);
        framed_items++;
    endtask

    task automatic send_payload(input logic [7:0] dat);
        in_item_t it;
        it = rand_item(KIND_PAYLOAD);
        it.data_byte = dat;
        send_item(it);
        framed_items++;
    endtask

    task automatic send_frame(input int len, input bit heavy_ff, input bit noisy);
        logic [7:0] dat;
        send_header(1'($urandom_range(0, 1)), pick_byte(), 16'(len));
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
            begin
                send_item(rand_item(KIND_HEADER));
            end
            dat = (heavy_ff && $urandom_range(0, 9) != 0) ? 8'hFF : pick_byte();
            send_payload(dat);
        end
    endtask

    initial
    begin
        int  len;
        int  sel;
        bit  wrap_done;

        rst_n        = 1'b0;
        push         = 1'b0;
        in_item      = '0;
        idle_mode    = 1'b1;
        hold_req     = 1'b0;
        sent_items   = 0;
        framed_items = 0;
        wrap_done    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(make_item(KIND_PAYLOAD, 1'b1, 8'hFF, 16'hFFFF, ESC_BYTE));
        send_header(1'b1, ESC_BYTE, 16'd0);
        send_header(1'b0, 8'hFF, 16'd1);
        send_payload(8'hFF);
        send_header(1'b0, 8'h00, 16'd2);
        send_item(rand_item(KIND_HEADER));
        send_payload(ESC_BYTE);
        send_payload(8'h00);
        send_header(1'b0, 8'h00, 16'd1);
        send_payload(8'hFF);
        send_header(1'b0, 8'hE0, 16'd16);
        repeat (16) send_payload(8'hFF);

        hold_req = 1'b1;
        framed_items = 0;
        while (framed_items < RANDOM_ITEMS)
        begin
            idle_mode = ($urandom_range(0, 2) != 0);
            sel = $urandom_range(0, 19);
            if (!wrap_done && framed_items > RANDOM_ITEMS / 4)
            begin
                wrap_done = 1'b1;
                send_frame(260, 1'b1, 1'b0);
            end
            else
            begin
                if (sel == 0)
                    len = 16;
                else if (sel < 4)
                    len = 0;
                else if (sel < 6)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);
                if ($urandom_range(0, 5) == 0)
                begin
                    send_item(rand_item(KIND_PAYLOAD));
                end
                send_frame(len, ($urandom_range(0, 7) == 0), 1'b1);
            end
        end

        idle_mode = 1'b0;
        send_frame(12, 1'b0, 1'b0);
        send_header(1'b1, pick_byte(), 16'hFFFF);
        repeat (3) send_payload(pick_byte());

        @(negedge clk);
        push <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d input transfers (%0d dropped), %0d frames closed",
                 sent_items, dropped_items, frames_closed);
        $display("checked %0d wire bytes, %0d mismatches", bytes_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
